>>> design/cal_pkg.sv
// ----------------------------------------------------------------------------
// cal_pkg: shared definitions for the calendar date counter
// Operation and status codes, calendar constants, the month length and leap
// year helpers, and the command and status bundles between control and data.
// ----------------------------------------------------------------------------
package cal_pkg;

  // Width of the day counter for the advance-by-count operation.
  localparam int COUNT_WIDTH = 16;
  localparam int CNT_W       = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;

  // Calendar limits.
  localparam logic [11:0] YEAR_MIN   = 12'd1900;
  localparam logic [11:0] YEAR_MAX   = 12'd2100;
  localparam logic [11:0] YEAR_TOP   = 12'd4095;
  localparam logic [3:0]  MONTH_JAN  = 4'd1;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;
  localparam logic [3:0]  MONTH_DEC  = 4'd12;
  localparam logic [4:0]  DAY_FIRST  = 5'd1;
  localparam logic [4:0]  DAY_LAST31 = 5'd31;
  localparam logic [4:0]  FEB_LEAP   = 5'd29;

  // Operation codes.
  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_ADV1 = 2'd1;
  localparam logic [1:0] OP_ADVN = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MONTH = 2'd1;
  localparam logic [1:0] ST_BAD_YEAR  = 2'd2;
  localparam logic [1:0] ST_BAD_DAY   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // apply a new request to the date registers
    logic step;  // advance one day and decrement the counter
    logic emit;  // copy the date and status into the output register
  } cal_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero_in;  // incoming day count is zero
    logic cnt_last;     // the counter holds its final day
    logic ceiling;      // date sits at the last representable day
  } cal_sts_t;

  // Nominal month lengths for a common year; codes outside 1..12 give 31.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Gregorian leap rule over the full 12-bit year range. The year is a
  // multiple of 100 exactly when it is a multiple of 4 and its quarter is a
  // multiple of 25; a multiple of 400 additionally has its low four bits clear.
  function automatic logic is_leap(input logic [11:0] y);
    logic [9:0] q;
    logic       mult25;
    q      = y[11:2];
    mult25 = 1'b0;
    for (int k = 0; k <= 40; k++) begin
      if (q == 10'(k * 25)) mult25 = 1'b1;
    end
    return (y[1:0] == 2'b00) && (!mult25 || (y[3:2] == 2'b00));
  endfunction

  // Days in month m of year y.
  function automatic logic [4:0] days_in(input logic [3:0] m, input logic [11:0] y);
    logic [4:0] len;
    len = month_len(m);
    if ((m == MONTH_FEB) && is_leap(y)) len = FEB_LEAP;
    return len;
  endfunction

endpackage

>>> design/calendar_date_counter_core.sv
// ----------------------------------------------------------------------------
// calendar_date_counter_core: Gregorian date counter
// Keeps a day, month and year and serves set, advance-one-day and
// advance-by-count requests, returning the date and a status for each.
// ----------------------------------------------------------------------------
//  Channel | Direction | Carries
//  in_     | sink      | request: op in tuser, set fields and day count in tdata
//  out_    | source    | result: date after the request and its status
//
//  Set, advance-one-day and unused op requests go from acceptance through the
//  hold state to the output register; advance-by-count steps through its day
//  count, one day per cycle through the shared advance logic, stopping early
//  at the last representable date. A new request is accepted once the previous
//  result has moved to the output register, even while that result stalls.
//  Reset (rst_n low, synchronous) sets the date to 1 January 1900.
// ----------------------------------------------------------------------------
module calendar_date_counter_core
  import cal_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // set_month[3:0], set_day[8:4], set_year[20:9],
                                  // day_count[36:21], zero fill[39:37]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // cur_month[3:0], cur_day[8:4], cur_year[20:9],
                                  // status[22:21], zero fill[23]
);

  cal_cmd_t    cmd;
  cal_sts_t    sts;
  logic [3:0]  cur_month;
  logic [4:0]  cur_day;
  logic [11:0] cur_year;
  logic [1:0]  status;

  // Request sequencing.
  cal_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Date registers and arithmetic.
  cal_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_op         (in_tuser),
    .in_set_month  (in_tdata[3:0]),
    .in_set_day    (in_tdata[8:4]),
    .in_set_year   (in_tdata[20:9]),
    .in_day_count  (in_tdata[36:21]),
    .sts           (sts),
    .out_cur_month (cur_month),
    .out_cur_day   (cur_day),
    .out_cur_year  (cur_year),
    .out_status    (status)
  );

  assign out_tdata = {1'b0, status, cur_year, cur_day, cur_month};

  // Taking a request drops in_tready, so requests are never taken back to back.
  a_one_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while the previous one was in progress");

  // An offered result always carries a real month.
  a_month_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((cur_month >= MONTH_JAN) && (cur_month <= MONTH_DEC)))
    else $error("result month out of range");

  // An offered result never drops below the first supported year or below day 1.
  a_year_floor : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((cur_year >= YEAR_MIN) && (cur_day >= DAY_FIRST)))
    else $error("result year or day below its floor");

endmodule

>>> design/cal_ctrl.sv
// ----------------------------------------------------------------------------
// cal_ctrl: request sequencer for the calendar date counter
// Takes a request, runs the day counter for advance-by-count, and hands the
// finished result to the output register once it is free.
// ----------------------------------------------------------------------------
module cal_ctrl
  import cal_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] in_op,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  cal_sts_t   sts,
  output cal_cmd_t   cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_COUNT = 2'd1;
  localparam logic [1:0] S_HOLD  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;
  logic       accept;
  logic       out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;

  // Command decode and next state.
  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    cmd.emit  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          if ((in_op == OP_ADVN) && !sts.cnt_zero_in) state_nxt = S_COUNT;
          else                                       state_nxt = S_HOLD;
        end
      end
      S_COUNT: begin
        // The ceiling holds the date, so the remaining count can be dropped.
        if (sts.ceiling) begin
          state_nxt = S_HOLD;
        end else begin
          cmd.step = 1'b1;
          if (sts.cnt_last) state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid flag.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.emit)        out_tvalid_nxt = 1'b1;
    else if (out_tready) out_tvalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule

>>> design/cal_dpath.sv
// ----------------------------------------------------------------------------
// cal_dpath: date registers and arithmetic for the calendar date counter
// Holds day, month and year, checks set requests, advances one day per step
// and keeps the day counter and the output register.
// ----------------------------------------------------------------------------
module cal_dpath
  import cal_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cal_cmd_t    cmd,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_set_month,
  input  logic [4:0]  in_set_day,
  input  logic [11:0] in_set_year,
  input  logic [15:0] in_day_count,
  output cal_sts_t    sts,
  output logic [3:0]  out_cur_month,
  output logic [4:0]  out_cur_day,
  output logic [11:0] out_cur_year,
  output logic [1:0]  out_status
);

  logic [3:0]       month_r, month_nxt;
  logic [4:0]       day_r, day_nxt;
  logic [11:0]      year_r, year_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] cnt_in;

  logic [3:0]  adv_month;
  logic [4:0]  adv_day;
  logic [11:0] adv_year;
  logic [4:0]  dim_cur;

  logic        m_ok, y_ok, d_ok, set_leap;
  logic [4:0]  dim_set;

  logic [3:0]  om_r;
  logic [4:0]  od_r;
  logic [11:0] oy_r;
  logic [1:0]  os_r;

  assign cnt_in = in_day_count[CNT_W-1:0];

  // One-day advance from the current date, carrying into month and year.
  always_comb begin
    dim_cur   = days_in(month_r, year_r);
    adv_month = month_r;
    adv_day   = day_r;
    adv_year  = year_r;
    if (day_r < dim_cur) begin
      adv_day = day_r + 5'd1;
    end else if (month_r < MONTH_DEC) begin
      adv_month = month_r + 4'd1;
      adv_day   = DAY_FIRST;
    end else if (year_r != YEAR_TOP) begin
      adv_year  = year_r + 12'd1;
      adv_month = MONTH_JAN;
      adv_day   = DAY_FIRST;
    end
  end

  // Set checks. Within 1900..2100 the only century years are 1900, 2000
  // and 2100, and of those only 2000 is a leap year.
  always_comb begin
    m_ok     = (in_set_month >= MONTH_JAN) && (in_set_month <= MONTH_DEC);
    y_ok     = (in_set_year >= YEAR_MIN) && (in_set_year <= YEAR_MAX);
    set_leap = (in_set_year[1:0] == 2'b00) && (in_set_year != YEAR_MIN)
               && (in_set_year != YEAR_MAX);
    dim_set  = month_len(in_set_month);
    if ((in_set_month == MONTH_FEB) && set_leap) dim_set = FEB_LEAP;
    d_ok     = (in_set_day >= DAY_FIRST) && (in_set_day <= dim_set);
  end

  // Next values of the date, status and counter registers.
  always_comb begin
    month_nxt  = month_r;
    day_nxt    = day_r;
    year_nxt   = year_r;
    status_nxt = status_r;
    cnt_nxt    = cnt_r;
    if (cmd.load) begin
      status_nxt = ST_OK;
      cnt_nxt    = cnt_in;
      case (in_op)
        OP_SET: begin
          if (!m_ok) begin
            status_nxt = ST_BAD_MONTH;
          end else begin
            month_nxt = in_set_month;
            if (!y_ok) begin
              status_nxt = ST_BAD_YEAR;
            end else begin
              year_nxt = in_set_year;
              if (!d_ok) status_nxt = ST_BAD_DAY;
              else       day_nxt    = in_set_day;
            end
          end
        end
        OP_ADV1: begin
          month_nxt = adv_month;
          day_nxt   = adv_day;
          year_nxt  = adv_year;
        end
        default: ;
      endcase
    end else if (cmd.step) begin
      month_nxt = adv_month;
      day_nxt   = adv_day;
      year_nxt  = adv_year;
      cnt_nxt   = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      month_r <= MONTH_JAN;
      day_r   <= DAY_FIRST;
      year_r  <= YEAR_MIN;
    end else begin
      month_r <= month_nxt;
      day_r   <= day_nxt;
      year_r  <= year_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    cnt_r    <= cnt_nxt;
  end

  // Output register, loaded when the controller hands over the result.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      om_r <= month_r;
      od_r <= day_r;
      oy_r <= year_r;
      os_r <= status_r;
    end
  end

  assign out_cur_month = om_r;
  assign out_cur_day   = od_r;
  assign out_cur_year  = oy_r;
  assign out_status    = os_r;

  // Status back to the controller.
  assign sts.cnt_zero_in = (cnt_in == '0);
  assign sts.cnt_last    = (cnt_r == CNT_W'(1));
  assign sts.ceiling     = (year_r == YEAR_TOP) && (month_r == MONTH_DEC)
                           && (day_r >= DAY_LAST31);

endmodule
